>>> hdl/pwc_pkg.sv
// Shared types and constants of the partition write combiner.
`timescale 1ns / 1ps

package pwc_pkg;

    // Slots in one staging row and the slot whose write sends the row out.
    localparam int       BURST     = 8;
    localparam logic [2:0] LAST_SLOT = 3'd7;

    // Item kinds carried in tuser.
    localparam logic [1:0] FUNC_ELEMENT  = 2'd0;
    localparam logic [1:0] FUNC_SET_BASE = 2'd1;
    localparam logic [1:0] FUNC_DRAIN    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PTR,
        ST_READ,
        ST_SEND
    } state_t;

endpackage

>>> hdl/partition_write_combiner.sv
// Partition write combiner: per-partition staging rows and write pointers with burst output.
`timescale 1ns / 1ps

// Scatters element values into per-partition regions. A set-base transaction, an element
// transaction that fills a staging slot other than the last, a drain of zero and any ignored
// transaction are taken in the idle state without leaving it. A transaction that writes n
// elements (a full row of eight, a drain of n, or one direct-mode element) moves to a state
// that takes the write pointer read from memory, then for each write to a state on the staging
// memory read port and a state that loads the output register through the single pointer
// adder, which waits while the output side stalls. The block is not ready meanwhile.
module partition_write_combiner #(
    parameter int PARTITIONS    = 256,
    parameter int ELEMENT_WIDTH = 64,
    parameter int ADDRESS_WIDTH = 48
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data,       // direct_mode
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // partition[7:0], slot[10:8], value[74:11], base_address[122:75], drain_count[126:123]
    input  logic [127:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,   // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // write_address[47:0], write_data[111:48]
    output logic [111:0] m_axis_tdata,
    output logic         m_axis_tlast    // last_of_burst
);
    import pwc_pkg::*;

    localparam int PW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int EW = ELEMENT_WIDTH;
    localparam int AW = ADDRESS_WIDTH;

    // Input fields.
    logic [7:0]  in_partition;
    logic [2:0]  in_slot;
    logic [63:0] in_value;
    logic [47:0] in_base;
    logic [3:0]  in_drain_count;
    logic [1:0]  in_func;

    assign in_partition   = s_axis_tdata[7:0];
    assign in_slot        = s_axis_tdata[10:8];
    assign in_value       = s_axis_tdata[74:11];
    assign in_base        = s_axis_tdata[122:75];
    assign in_drain_count = s_axis_tdata[126:123];
    assign in_func        = s_axis_tuser;

    state_t          state_reg, state_next;
    logic            direct_mode_reg;
    logic [PW-1:0]   row_reg, row_next;
    logic [2:0]      idx_reg, idx_next;
    logic [3:0]      count_reg, count_next;
    logic [EW-1:0]   value_reg, value_next;
    logic            direct_item_reg, direct_item_next;
    logic [AW-1:0]   addr_reg, addr_next;
    logic [AW-1:0]   ptr_rd_reg;
    logic [EW-1:0]   stage_rd_reg;
    logic [47:0]     out_addr_reg, out_addr_next;
    logic [63:0]     out_data_reg, out_data_next;
    logic            out_last_reg, out_last_next;
    logic            out_valid_reg, out_valid_next;

    logic [AW-1:0]   ptr_mem [PARTITIONS];
    logic [EW-1:0]   stage_mem [PARTITIONS*BURST];

    logic            accept;
    logic            in_range;
    logic [PW-1:0]   in_row;
    logic [3:0]      drain_sat;
    logic            out_free;
    logic            is_last;
    logic [AW-1:0]   addr_inc;
    logic            ptr_we;
    logic [PW-1:0]   ptr_wa;
    logic [AW-1:0]   ptr_wd;
    logic            stage_we;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_range      = {24'd0, in_partition} < 32'(PARTITIONS);
    assign in_row        = PW'(in_partition);
    assign drain_sat     = (in_drain_count > 4'(BURST)) ? 4'(BURST) : in_drain_count;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign is_last       = (({1'b0, idx_reg} + 4'd1) == count_reg);
    // The one adder that steps the write address for every emitted write.
    assign addr_inc      = addr_reg + AW'(1);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg, out_addr_reg};
    assign m_axis_tlast  = out_last_reg;

    // A pointer is loaded by a set-base transaction or written back after the final write.
    assign ptr_we   = (accept && in_range && in_func == FUNC_SET_BASE)
                   || (state_reg == ST_SEND && out_free && is_last);
    assign ptr_wa   = (state_reg == ST_IDLE) ? in_row : row_reg;
    assign ptr_wd   = (state_reg == ST_IDLE) ? AW'(in_base) : addr_inc;
    assign stage_we = accept && in_range && in_func == FUNC_ELEMENT && !direct_mode_reg;

    always_comb
    begin
        state_next       = state_reg;
        row_next         = row_reg;
        idx_next         = idx_reg;
        count_next       = count_reg;
        value_next       = value_reg;
        direct_item_next = direct_item_reg;
        addr_next        = addr_reg;
        out_addr_next    = out_addr_reg;
        out_data_next    = out_data_reg;
        out_last_next    = out_last_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_range)
                begin
                    row_next   = in_row;
                    value_next = EW'(in_value);
                    idx_next   = 3'd0;
                    case (in_func)
                        FUNC_ELEMENT:
                        begin
                            if (direct_mode_reg)
                            begin
                                direct_item_next = 1'b1;
                                count_next       = 4'd1;
                                state_next       = ST_PTR;
                            end
                            else if (in_slot == LAST_SLOT)
                            begin
                                direct_item_next = 1'b0;
                                count_next       = 4'(BURST);
                                state_next       = ST_PTR;
                            end
                        end
                        FUNC_DRAIN:
                        begin
                            if (drain_sat != 4'd0)
                            begin
                                direct_item_next = 1'b0;
                                count_next       = drain_sat;
                                state_next       = ST_PTR;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_PTR:
            begin
                addr_next  = ptr_rd_reg;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = 48'(addr_reg);
                    out_data_next  = direct_item_reg ? 64'(value_reg) : 64'(stage_rd_reg);
                    out_last_next  = is_last;
                    addr_next      = addr_inc;
                    idx_next       = idx_reg + 3'd1;
                    state_next     = is_last ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            direct_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                direct_mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg         <= row_next;
        idx_reg         <= idx_next;
        count_reg       <= count_next;
        value_reg       <= value_next;
        direct_item_reg <= direct_item_next;
        addr_reg        <= addr_next;
        out_addr_reg    <= out_addr_next;
        out_data_reg    <= out_data_next;
        out_last_reg    <= out_last_next;
    end

    // Pointer memory: read at the incoming partition, written by one port.
    always_ff @(posedge clk)
    begin
        ptr_rd_reg <= ptr_mem[in_row];
        if (ptr_we)
        begin
            ptr_mem[ptr_wa] <= ptr_wd;
        end
    end

    // Staging memory: one row of eight slots per partition.
    always_ff @(posedge clk)
    begin
        stage_rd_reg <= stage_mem[{row_reg, idx_reg}];
        if (stage_we)
        begin
            stage_mem[{in_row, in_slot}] <= EW'(in_value);
        end
    end

`ifndef SYNTH
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_SEND) |->
            (count_reg != 4'd0 && count_reg <= 4'(BURST) && {1'b0, idx_reg} < count_reg))
        else $error("write index or count out of range");

    a_valid_from_send: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_SEND))
        else $error("output became valid outside the send state");

    a_final_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEND && out_free && is_last) |=>
            (state_reg == ST_IDLE && m_axis_tvalid && m_axis_tlast))
        else $error("final write not marked last or sequencer did not return to idle");

    a_set_base_single: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_range && in_func == FUNC_SET_BASE) |=> (state_reg == ST_IDLE))
        else $error("set-base transaction started a write sequence");
`endif

endmodule

>>> sim/tb_partition_write_combiner.sv
// Self-checking testbench for the partition write combiner: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_partition_write_combiner;

    import pwc_pkg::*;

    localparam int         PARTITION_COUNT = 256;
    localparam int         SETTLE_CYCLES   = 24;
    localparam int         PHASES          = 6;
    localparam int         PHASE_ITEMS     = 68;
    localparam int         IDLE_PERCENT    = 26;
    localparam int         HOT_PARTITIONS  = 12;
    localparam logic [1:0] FUNC_UNUSED     = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  part;
        logic [2:0]  slot;
        logic [63:0] value;
        logic [47:0] base;
        logic [3:0]  count;
    } part_item_t;

    typedef struct packed {
        logic [47:0] addr;
        logic [63:0] data;
        logic        last;
    } mem_write_t;

    typedef enum logic [1:0] {
        ROW_CONFIG,
        ROW_PREDICT,
        ROW_QUIET,
        ROW_ONE_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        part_item_t item;
        mem_write_t write;
    } stim_row_t;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         cfg_valid     = 1'b0;
    logic         cfg_ready;
    logic         cfg_data      = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // partition, slot, value, base_address, drain_count, from bit 0 up
    logic [127:0] s_axis_tdata  = '0;
    logic [1:0]   s_axis_tuser  = FUNC_ELEMENT;  // func
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // write_address, write_data, from bit 0 up
    logic [111:0] m_axis_tdata;
    logic         m_axis_tlast;                  // last_of_burst

    // Shadow copy of the block's state.
    logic [63:0]  staged_values [PARTITION_COUNT][BURST];
    logic [47:0]  region_pointer [PARTITION_COUNT];
    bit           pointer_known [PARTITION_COUNT];
    bit           slot_known [PARTITION_COUNT][BURST];
    bit   [2:0]   next_slot [PARTITION_COUNT];
    bit           mode_is_direct = 1'b0;

    mem_write_t   writes_due[$];
    stim_row_t    directed_rows[$];
    int           error_count    = 0;
    bit           steady_stretch = 1'b0;

    partition_write_combiner dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("partition_write_combiner verification failed");
        $finish;
    end

    // Writes out the first n staged values of a partition and moves its pointer past them.
    function automatic void flush_row(logic [7:0] p, int n, bit record);
        logic [47:0] ptr;
        mem_write_t  w;
        ptr = region_pointer[p];
        for (int i = 0; i < n; i++)
        begin
            w.addr = ptr + 48'(i);
            w.data = staged_values[p][i];
            w.last = (i == n - 1);
            if (record)
                writes_due.push_back(w);
        end
        region_pointer[p] = ptr + 48'(n);
    endfunction

    function automatic void scatter_item(part_item_t it, bit record);
        mem_write_t w;
        int         n;
        case (it.func)
            FUNC_ELEMENT:
                if (mode_is_direct)
                begin
                    w.addr = region_pointer[it.part];
                    w.data = it.value;
                    w.last = 1'b1;
                    if (record)
                        writes_due.push_back(w);
                    region_pointer[it.part] = region_pointer[it.part] + 48'd1;
                end
                else
                begin
                    staged_values[it.part][it.slot] = it.value;
                    slot_known[it.part][it.slot]    = 1'b1;
                    if (it.slot == LAST_SLOT)
                        flush_row(it.part, BURST, record);
                end
            FUNC_SET_BASE:
            begin
                region_pointer[it.part] = it.base;
                pointer_known[it.part]  = 1'b1;
            end
            FUNC_DRAIN:
            begin
                n = (it.count > BURST) ? BURST : int'(it.count);
                flush_row(it.part, n, record);
            end
            default:
            begin
            end
        endcase
    endfunction

    // Picks a legal transaction: nothing may read a pointer or slot that was never written.
    function automatic part_item_t random_item();
        part_item_t it;
        int         pick;
        int         n;
        it.part  = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, HOT_PARTITIONS - 1))
                                                : 8'($urandom_range(0, 255));
        it.slot  = 3'($urandom_range(0, 7));
        it.value = {$urandom, $urandom};
        it.base  = ($urandom_range(0, 9) == 0) ? {44'hFFF_FFFF_FFFF, 4'($urandom_range(0, 15))}
                                               : {16'($urandom), $urandom};
        it.count = 4'($urandom_range(0, 15));
        pick     = $urandom_range(0, 99);
        if (!pointer_known[it.part] || pick < 6)
            it.func = FUNC_SET_BASE;
        else if (pick < 16)
            it.func = FUNC_DRAIN;
        else if (pick < 20)
            it.func = FUNC_UNUSED;
        else
            it.func = FUNC_ELEMENT;

        if (it.func == FUNC_ELEMENT && !mode_is_direct)
        begin
            // Mostly fill rows in order so that bursts go out regularly.
            if ($urandom_range(0, 3) != 0)
                it.slot = next_slot[it.part];
            if (it.slot == LAST_SLOT)
            begin
                for (int s = LAST_SLOT - 1; s >= 0; s--)
                    if (!slot_known[it.part][s])
                        it.slot = 3'(s);
            end
            next_slot[it.part] = it.slot + 3'd1;
        end

        if (it.func == FUNC_DRAIN)
        begin
            n = 0;
            while (n < BURST && slot_known[it.part][n])
                n++;
            if (n < BURST && it.count > n)
                it.count = 4'(n);
        end
        return it;
    endfunction

    function automatic void add_row(row_kind_t kind, logic [1:0] func, logic [7:0] part,
                                    logic [2:0] slot, logic [63:0] value, logic [47:0] base,
                                    logic [3:0] count, logic [47:0] addr = '0,
                                    logic [63:0] data = '0);
        stim_row_t row;
        row.kind        = kind;
        row.item.func   = func;
        row.item.part   = part;
        row.item.slot   = slot;
        row.item.value  = value;
        row.item.base   = base;
        row.item.count  = count;
        row.write.addr  = addr;
        row.write.data  = data;
        row.write.last  = 1'b1;
        directed_rows.push_back(row);
    endfunction

    task automatic send_item(part_item_t it, bit record);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.func;
        s_axis_tdata  <= {1'b0, it.count, it.base, it.value, it.slot, it.part};
        do @(posedge clk); while (!s_axis_tready);
        scatter_item(it, record);
        if (!steady_stretch && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    endtask

    task automatic wait_for_writes();
        s_axis_tvalid <= 1'b0;
        while (writes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(bit mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        mode_is_direct = mode;
    endtask

    always @(posedge clk)
        m_axis_tready <= steady_stretch || ($urandom_range(0, 99) >= IDLE_PERCENT);

    always @(posedge clk)
    begin
        mem_write_t got;
        mem_write_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[47:0], m_axis_tdata[111:48], m_axis_tlast};
            if (writes_due.size() == 0)
            begin
                $error("unexpected write: write_address %h write_data %h last_of_burst %b",
                       got.addr, got.data, got.last);
                error_count++;
            end
            else
            begin
                want = writes_due.pop_front();
                if (got.addr !== want.addr)
                begin
                    $error("write_address mismatch: expected %h, actual %h", want.addr, got.addr);
                    error_count++;
                end
                if (got.data !== want.data)
                begin
                    $error("write_data mismatch: expected %h, actual %h", want.data, got.data);
                    error_count++;
                end
                if (got.last !== want.last)
                begin
                    $error("last_of_burst mismatch: expected %b, actual %b", want.last, got.last);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t row;
        bit        mode;

        // Staged mode after reset; partition 255 sits just below the address wrap.
        add_row(ROW_QUIET, FUNC_SET_BASE, 8'd0, 3'd0, '0, 48'h0, 4'd0);
        add_row(ROW_QUIET, FUNC_SET_BASE, 8'd255, 3'd0, '0, 48'hFFFF_FFFF_FFFC, 4'd0);
        for (int s = 0; s < LAST_SLOT; s++)
            add_row(ROW_QUIET, FUNC_ELEMENT, 8'd255, 3'(s),
                    (s == 0) ? 64'h0 : (s == 1) ? '1 : {$urandom, $urandom}, '0, 4'd0);
        add_row(ROW_PREDICT, FUNC_ELEMENT, 8'd255, LAST_SLOT, 64'h8000_0000_0000_0001, '0, 4'd0);
        add_row(ROW_QUIET, FUNC_UNUSED, 8'd0, 3'd7, '1, '1, 4'd15);
        add_row(ROW_QUIET, FUNC_DRAIN, 8'd255, 3'd0, '0, '0, 4'd0);
        // A count above eight saturates to a full row.
        add_row(ROW_PREDICT, FUNC_DRAIN, 8'd255, 3'd0, '0, '0, 4'd15);
        add_row(ROW_PREDICT, FUNC_DRAIN, 8'd255, 3'd0, '0, '0, 4'd3);
        add_row(ROW_QUIET, FUNC_SET_BASE, 8'd0, 3'd0, '0, 48'hFFFF_FFFF_FFFF, 4'd0);
        add_row(ROW_CONFIG, FUNC_ELEMENT, 8'd0, 3'd0, 64'd1, '0, 4'd0);
        add_row(ROW_ONE_WRITE, FUNC_ELEMENT, 8'd0, LAST_SLOT, '1, '0, 4'd0,
                48'hFFFF_FFFF_FFFF, '1);
        add_row(ROW_ONE_WRITE, FUNC_ELEMENT, 8'd0, 3'd0, 64'h0, '0, 4'd0, 48'h0, 64'h0);
        add_row(ROW_ONE_WRITE, FUNC_ELEMENT, 8'd0, 3'd3, 64'hA5A5_5A5A_0F0F_F0F0, '0, 4'd0,
                48'h1, 64'hA5A5_5A5A_0F0F_F0F0);
        // A drain in direct mode still reads the staging row.
        add_row(ROW_PREDICT, FUNC_DRAIN, 8'd255, 3'd0, '0, '0, 4'd2);
        add_row(ROW_QUIET, FUNC_SET_BASE, 8'd128, 3'd0, '0, 48'h5555_5555_5555, 4'd0);
        add_row(ROW_ONE_WRITE, FUNC_ELEMENT, 8'd128, 3'd5, 64'h1234_5678_9ABC_DEF0, '0, 4'd0,
                48'h5555_5555_5555, 64'h1234_5678_9ABC_DEF0);
        add_row(ROW_CONFIG, FUNC_ELEMENT, 8'd0, 3'd0, 64'd0, '0, 4'd0);
        add_row(ROW_PREDICT, FUNC_DRAIN, 8'd255, 3'd0, '0, '0, 4'd8);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            case (row.kind)
                ROW_CONFIG:
                begin
                    wait_for_writes();
                    write_mode(row.item.value[0]);
                end
                ROW_ONE_WRITE:
                begin
                    writes_due.push_back(row.write);
                    send_item(row.item, 1'b0);
                end
                ROW_QUIET:
                    send_item(row.item, 1'b0);
                default:
                    send_item(row.item, 1'b1);
            endcase
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_for_writes();
            mode = (phase == 4) ? 1'($urandom_range(0, 1)) : 1'(phase % 2);
            write_mode(mode);
            steady_stretch = (phase == 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Halfway through, hold back until the block has caught up.
                if (i == PHASE_ITEMS / 2)
                    wait_for_writes();
                send_item(random_item(), 1'b1);
            end
        end
        steady_stretch = 1'b0;
        wait_for_writes();

        if (error_count == 0)
            $display("partition_write_combiner verification clean");
        else
            $display("partition_write_combiner verification failed");
        $finish;
    end

endmodule

>>> partition_write_combiner.f
hdl/pwc_pkg.sv
hdl/partition_write_combiner.sv
sim/tb_partition_write_combiner.sv
